@@ rtl/biquad_df2_filter_unit_macros.svh @@
// Assertion macros for the biquad filter unit.
// Used by the top level; no dependencies.
`ifndef BIQUAD_DF2_FILTER_UNIT_MACROS_SVH
`define BIQUAD_DF2_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// Next-cycle implication, disabled in reset.
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

@@ rtl/bqdf2_pkg.sv @@
// Package for the biquad filter unit: widths, codes and the microcode ROM.
// No dependencies.
`default_nettype none

package bqdf2_pkg;

    localparam int NUM_CHANNELS   = 8;
    localparam int COEF_FRAC_BITS = 14;

    localparam int SAMPLE_W = 24;
    localparam int CHAN_W   = 3;
    localparam int COEF_W   = 18;
    localparam int STATE_W  = 32;
    localparam int PROD_W   = COEF_W + STATE_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int STEP_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic [2:0] COEF_SEL_B0 = 3'd0;
    localparam logic [2:0] COEF_SEL_B1 = 3'd1;
    localparam logic [2:0] COEF_SEL_B2 = 3'd2;
    localparam logic [2:0] COEF_SEL_A1 = 3'd3;
    localparam logic [2:0] COEF_SEL_A2 = 3'd4;

    localparam logic [1:0] DATA_SEL_W1 = 2'd0;
    localparam logic [1:0] DATA_SEL_W2 = 2'd1;
    localparam logic [1:0] DATA_SEL_WN = 2'd2;

    localparam logic [2:0] ACC_HOLD   = 3'd0;
    localparam logic [2:0] ACC_LOAD_X = 3'd1;
    localparam logic [2:0] ACC_CLR    = 3'd2;
    localparam logic [2:0] ACC_ADD    = 3'd3;
    localparam logic [2:0] ACC_SUB    = 3'd4;

    localparam logic [STEP_W-1:0] STEP_FIRST  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

    typedef struct packed {
        logic [2:0]        coef_sel;
        logic [1:0]        data_sel;
        logic [2:0]        acc_op;
        logic              save_w;
        logic              finish;
        logic              jmp_bad;
        logic [STEP_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '{COEF_SEL_B0, DATA_SEL_W1, ACC_HOLD, 1'b0, 1'b0, 1'b0, STEP_FIRST};
        unique case (step)
            3'd0: uc = '{COEF_SEL_A1, DATA_SEL_W1, ACC_LOAD_X, 1'b0, 1'b0, 1'b1, STEP_FINISH};
            3'd1: uc = '{COEF_SEL_A2, DATA_SEL_W2, ACC_SUB, 1'b0, 1'b0, 1'b0, STEP_FIRST};
            3'd2: uc = '{COEF_SEL_B0, DATA_SEL_W1, ACC_SUB, 1'b0, 1'b0, 1'b0, STEP_FIRST};
            3'd3: uc = '{COEF_SEL_B1, DATA_SEL_W1, ACC_CLR, 1'b1, 1'b0, 1'b0, STEP_FIRST};
            3'd4: uc = '{COEF_SEL_B2, DATA_SEL_W2, ACC_ADD, 1'b0, 1'b0, 1'b0, STEP_FIRST};
            3'd5: uc = '{COEF_SEL_B0, DATA_SEL_WN, ACC_ADD, 1'b0, 1'b0, 1'b0, STEP_FIRST};
            3'd6: uc = '{COEF_SEL_B0, DATA_SEL_W1, ACC_ADD, 1'b0, 1'b0, 1'b0, STEP_FIRST};
            3'd7: uc = '{COEF_SEL_B0, DATA_SEL_W1, ACC_HOLD, 1'b0, 1'b1, 1'b0, STEP_FIRST};
            default: uc = '{COEF_SEL_B0, DATA_SEL_W1, ACC_HOLD, 1'b0, 1'b0, 1'b0, STEP_FIRST};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/biquad_df2_filter_unit.sv @@
// Multichannel direct form II biquad filter unit, microcoded datapath.
// Depends on bqdf2_pkg and biquad_df2_filter_unit_macros.svh.
//
// Usage:
//   Input stream: s_tdata carries the 24-bit signed sample, s_tuser the
//   channel number. A transfer takes place when s_tvalid and s_tready are high.
//   Result stream: m_tdata carries the filtered, saturated 24-bit sample.
//   Configuration: cfg_index selects b0, b1, b2, a1, a2 (0..4), cfg_data holds
//   the Q3.14 coefficient; cfg_ready is high whenever reset is released.
//   Write only while idle.
//   Timing: a sample is worked by an eight-step microprogram around one
//   18x32 multiplier and one accumulator; the result is written to the
//   output register at the last step, and a new sample is taken in the
//   cycle after that step, so no sample is taken while one is in work.
//   A channel number beyond the channel count yields 0 and leaves state alone.
//   Stall: a waiting result holds in the output register; a following sample
//   is worked up to its last step and waits there until the register frees.
//   Reset: all per-channel delays clear to zero, b0 returns to 1.0 and the
//   other coefficients to zero; no transfer is taken while reset is asserted.
`default_nettype none
`include "biquad_df2_filter_unit_macros.svh"

module biquad_df2_filter_unit (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [bqdf2_pkg::SAMPLE_W-1:0]        s_tdata,  // [23:0] sample_in
    input  wire  [bqdf2_pkg::CHAN_W-1:0]          s_tuser,  // [2:0] chan
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [bqdf2_pkg::SAMPLE_W-1:0]        m_tdata,  // [23:0] sample_out
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [bqdf2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [bqdf2_pkg::COEF_W-1:0]          cfg_data
);

    localparam int SW = bqdf2_pkg::STATE_W;
    localparam int AW = bqdf2_pkg::ACC_W;
    localparam int F  = bqdf2_pkg::COEF_FRAC_BITS;
    localparam logic [bqdf2_pkg::STEP_W-1:0] FIRST_STEP = bqdf2_pkg::STEP_FIRST;
    localparam logic [bqdf2_pkg::STEP_W-1:0] LAST_STEP  = bqdf2_pkg::STEP_FINISH;

    logic signed [bqdf2_pkg::COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [SW-1:0] delay_one_reg [bqdf2_pkg::NUM_CHANNELS];
    logic signed [SW-1:0] delay_two_reg [bqdf2_pkg::NUM_CHANNELS];

    logic                                 busy_reg, busy_next;
    logic [bqdf2_pkg::STEP_W-1:0]         step_reg, step_next;
    logic signed [bqdf2_pkg::SAMPLE_W-1:0] sample_reg;
    logic [bqdf2_pkg::CHAN_W-1:0]         chan_reg;
    logic signed [bqdf2_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [AW-1:0]                 acc_reg, acc_next;
    logic signed [SW-1:0]                 w_reg;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [bqdf2_pkg::SAMPLE_W-1:0]       m_tdata_reg;

    bqdf2_pkg::ucode_t                    uc;
    logic                                 s_xfer, chan_bad, out_free, finish_go;
    logic                                 finish_wait;
    logic signed [SW-1:0]                 w1, w2, data_val;
    logic signed [bqdf2_pkg::COEF_W-1:0]  coef_val;
    logic signed [AW-1:0]                 prod_ext, x_ext, rnd;
    logic signed [SW-1:0]                 w_sat;
    logic signed [bqdf2_pkg::SAMPLE_W-1:0] y_sat;

    assign uc          = bqdf2_pkg::ucode_rom(step_reg);
    assign s_tready    = aresetn && !busy_reg;
    assign s_xfer      = s_tvalid && s_tready;
    assign cfg_ready   = aresetn;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign chan_bad    = int'(chan_reg) >= bqdf2_pkg::NUM_CHANNELS;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_go   = busy_reg && uc.finish && out_free;
    assign finish_wait = busy_reg && uc.finish && !out_free;

    assign w1 = delay_one_reg[chan_reg];
    assign w2 = delay_two_reg[chan_reg];

    always_comb begin
        case (uc.coef_sel)
            bqdf2_pkg::COEF_SEL_B0: coef_val = b0_reg;
            bqdf2_pkg::COEF_SEL_B1: coef_val = b1_reg;
            bqdf2_pkg::COEF_SEL_B2: coef_val = b2_reg;
            bqdf2_pkg::COEF_SEL_A1: coef_val = a1_reg;
            bqdf2_pkg::COEF_SEL_A2: coef_val = a2_reg;
            default:                coef_val = '0;
        endcase
        case (uc.data_sel)
            bqdf2_pkg::DATA_SEL_W1: data_val = w1;
            bqdf2_pkg::DATA_SEL_W2: data_val = w2;
            bqdf2_pkg::DATA_SEL_WN: data_val = w_reg;
            default:                data_val = '0;
        endcase
    end

    assign prod_next = coef_val * data_val;
    assign prod_ext  = {{(AW - bqdf2_pkg::PROD_W){prod_reg[bqdf2_pkg::PROD_W-1]}}, prod_reg};
    assign x_ext     = {{(AW - bqdf2_pkg::SAMPLE_W - F){sample_reg[bqdf2_pkg::SAMPLE_W-1]}},
                        sample_reg, {F{1'b0}}};

    always_comb begin
        case (uc.acc_op)
            bqdf2_pkg::ACC_LOAD_X: acc_next = x_ext;
            bqdf2_pkg::ACC_CLR:    acc_next = '0;
            bqdf2_pkg::ACC_ADD:    acc_next = acc_reg + prod_ext;
            bqdf2_pkg::ACC_SUB:    acc_next = acc_reg - prod_ext;
            default:               acc_next = acc_reg;
        endcase
    end

    // round half up, then saturate
    assign rnd = (acc_reg + bqdf2_pkg::ROUND_HALF) >>> F;

    always_comb begin
        if (rnd > AW'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
            w_sat = {1'b0, {(SW-1){1'b1}}};
        end else if (rnd < -AW'(signed'({1'b0, {(SW-1){1'b1}}})) - AW'(1)) begin
            w_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_sat = rnd[SW-1:0];
        end
        if (rnd > AW'(signed'({1'b0, {(bqdf2_pkg::SAMPLE_W-1){1'b1}}}))) begin
            y_sat = {1'b0, {(bqdf2_pkg::SAMPLE_W-1){1'b1}}};
        end else if (rnd < -AW'(signed'({1'b0, {(bqdf2_pkg::SAMPLE_W-1){1'b1}}})) - AW'(1))
        begin
            y_sat = {1'b1, {(bqdf2_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            y_sat = rnd[bqdf2_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (s_xfer) begin
            busy_next = 1'b1;
            step_next = bqdf2_pkg::STEP_FIRST;
        end else if (busy_reg) begin
            if (uc.finish) begin
                if (out_free) begin
                    busy_next     = 1'b0;
                    step_next     = bqdf2_pkg::STEP_FIRST;
                    m_tvalid_next = 1'b1;
                end
            end else if (uc.jmp_bad && chan_bad) begin
                step_next = uc.target;
            end else begin
                step_next = step_reg + bqdf2_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= bqdf2_pkg::STEP_FIRST;
            m_tvalid_reg <= 1'b0;
            b0_reg       <= bqdf2_pkg::COEF_ONE;
            b1_reg       <= '0;
            b2_reg       <= '0;
            a1_reg       <= '0;
            a2_reg       <= '0;
            for (int i = 0; i < bqdf2_pkg::NUM_CHANNELS; i++) begin
                delay_one_reg[i] <= '0;
                delay_two_reg[i] <= '0;
            end
        end else begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    bqdf2_pkg::REG_B0: b0_reg <= cfg_data;
                    bqdf2_pkg::REG_B1: b1_reg <= cfg_data;
                    bqdf2_pkg::REG_B2: b2_reg <= cfg_data;
                    bqdf2_pkg::REG_A1: a1_reg <= cfg_data;
                    bqdf2_pkg::REG_A2: a2_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (finish_go && !chan_bad) begin
                delay_two_reg[chan_reg] <= w1;
                delay_one_reg[chan_reg] <= w_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sample_reg <= s_tdata;
            chan_reg   <= s_tuser;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (busy_reg && uc.save_w) begin
            w_reg <= w_sat;
        end
        if (finish_go) begin
            m_tdata_reg <= chan_bad ? '0 : y_sat;
        end
    end

    `BQ_ASSERT_NOW(a_idle_step_zero, aclk, aresetn, !busy_reg, step_reg == FIRST_STEP)
    `BQ_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_xfer, busy_reg && step_reg == FIRST_STEP)
    `BQ_ASSERT_NEXT(a_finish_holds, aclk, aresetn, finish_wait, step_reg == LAST_STEP)

endmodule

`default_nettype wire

@@ verif/biquad_sb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the biquad filter unit: tracks coefficients and per-channel
// delays, predicts each filtered sample and compares results. Needs bqdf2_pkg.
package biquad_sb_pkg;

    import bqdf2_pkg::*;

    localparam int MAX_REPORTS = 10;

    class biquad_scoreboard;

        longint ff0, ff1, ff2, fb1, fb2;
        longint hist1[NUM_CHANNELS];
        longint hist2[NUM_CHANNELS];
        logic [SAMPLE_W-1:0] filtered_q[$];
        int unsigned inputs_seen;
        int unsigned results_seen;
        int unsigned coef_writes;
        int unsigned failures;

        function new();
            ff0 = longint'(COEF_ONE);
            ff1 = 0;
            ff2 = 0;
            fb1 = 0;
            fb2 = 0;
            foreach (hist1[i]) begin
                hist1[i] = 0;
                hist2[i] = 0;
            end
            inputs_seen = 0;
            results_seen = 0;
            coef_writes = 0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            longint c;
            c = longint'($signed(data));
            coef_writes++;
            case (idx)
                REG_B0: ff0 = c;
                REG_B1: ff1 = c;
                REG_B2: ff2 = c;
                REG_A1: fb1 = c;
                REG_A2: fb2 = c;
                default: ;
            endcase
        endfunction

        function longint round_clip(longint acc, int width);
            longint v;
            longint hi;
            longint lo;
            v = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            hi = (longint'(1) <<< (width - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function logic [SAMPLE_W-1:0] filter_sample(logic [SAMPLE_W-1:0] smp,
                                                    logic [CHAN_W-1:0] ch);
            longint x, w1, w2, w, y;
            if (int'(ch) >= NUM_CHANNELS) return '0;
            x = longint'($signed(smp));
            w1 = hist1[ch];
            w2 = hist2[ch];
            w = round_clip((x <<< COEF_FRAC_BITS) - fb1 * w1 - fb2 * w2, STATE_W);
            y = round_clip(ff0 * w + ff1 * w1 + ff2 * w2, SAMPLE_W);
            hist2[ch] = w1;
            hist1[ch] = w;
            return y[SAMPLE_W-1:0];
        endfunction

        function void note_input(logic [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] ch);
            inputs_seen++;
            filtered_q.push_back(filter_sample(smp, ch));
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            results_seen++;
            if (filtered_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d: sample_out %h with nothing outstanding",
                             results_seen, got);
                return;
            end
            want = filtered_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d: sample_out expected %h, got %h",
                             results_seen, want, got);
            end
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

    endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench for biquad_df2_filter_unit: drives samples and
// coefficient writes under varying flow control. Needs bqdf2_pkg, biquad_sb_pkg.
module tb_top;

    import bqdf2_pkg::*;
    import biquad_sb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LATENCY     = 10;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 80;
    localparam int LAST_INDEX  = (1 << CFG_IDX_W) - 1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [SAMPLE_W-1:0] s_tdata;   // [23:0] sample_in
    logic [CHAN_W-1:0] s_tuser;     // [2:0] chan
    logic m_tvalid;
    logic m_tready;
    logic [SAMPLE_W-1:0] m_tdata;   // [23:0] sample_out
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int settings_used = 0;
    biquad_scoreboard sb;

    biquad_df2_filter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles = quiet_cycles + 1;
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tdata, s_tuser);
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = smp;
        s_tuser = ch;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                              input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                              input logic [COEF_W-1:0] a2);
        wait_drained();
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        for (int i = REG_A2 + 1; i <= LAST_INDEX; i++)
            write_coef(CFG_IDX_W'(i), COEF_W'($urandom));
        settings_used++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3, 4: return SAMPLE_W'(int'($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_coefs(input bit stable);
        int a1, a2, lim;
        if (stable) begin
            a2 = int'($urandom_range(2 * 14745)) - 14745;
            lim = (16384 + a2) * 9 / 10;
            a1 = int'($urandom_range(2 * lim)) - lim;
            load_coefs(COEF_W'(int'($urandom_range(32767)) - 16384),
                       COEF_W'(int'($urandom_range(32767)) - 16384),
                       COEF_W'(int'($urandom_range(32767)) - 16384),
                       COEF_W'(a1), COEF_W'(a2));
        end else begin
            load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                       COEF_W'($urandom), COEF_W'($urandom));
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset coefficients pass samples straight through
        send_sample(SAMPLE_MAX, 3'd0);
        send_sample(SAMPLE_MIN, 3'd7);
        send_sample('0, 3'd3);
        send_sample('1, 3'd1);
        send_sample(SAMPLE_W'(1), 3'd2);
        send_sample({(SAMPLE_W/2){2'b01}}, 3'd4);
        send_sample({(SAMPLE_W/2){2'b10}}, 3'd5);
        send_sample(SAMPLE_MAX, 3'd6);

        // drive the intermediate and output into saturation
        load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        repeat (6) send_sample(SAMPLE_MAX, 3'd0);
        repeat (4) send_sample(SAMPLE_MIN, 3'd1);
        load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        repeat (3) begin
            send_sample(SAMPLE_MIN, 3'd2);
            send_sample(SAMPLE_MAX, 3'd2);
        end

        for (int p = 0; p < PHASES; p++) begin
            random_coefs(p % 2 == 0);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(49) == 0) wait_drained();
                send_sample(pick_sample(), CHAN_W'($urandom));
            end
        end

        wait_drained();
        idle_pct = 0;
        stall_pct = 0;
        repeat (2 * LATENCY) @(negedge aclk);
        sb.failures = sb.failures + sb.pending();
        $display("Filtered %0d samples across %0d coefficient sets and four flow-control mixes.",
                 sb.inputs_seen, settings_used);
        $display("Checked %0d results after %0d register writes; %0d failures.",
                 sb.results_seen, sb.coef_writes, sb.failures);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ biquad_df2_filter_unit.f @@
+incdir+rtl
rtl/bqdf2_pkg.sv
rtl/biquad_df2_filter_unit.sv
verif/biquad_sb_pkg.sv
verif/tb_top.sv
